[hdl/jvp_pkg.sv]
// Shared constants and codes for the joint velocity profile block.
// No dependencies.
package jvp_pkg;

	localparam int OUT_W     = 16;   // velocity result width
	localparam int CFG_W     = 16;   // configuration write data width
	localparam int TOL_W     = 15;
	localparam int SPEED_W   = 16;
	localparam int CIDX_W    = 3;
	localparam int PEAK_K    = 2000; // 2 * 1000 ms per second
	localparam int PEAK_K_W  = 11;
	localparam int QUO_W     = OUT_W - 1; // quotient bits below saturation

	localparam logic [OUT_W-1:0] VEL_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] VEL_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic             RST_MODE  = 1'b1;
	localparam logic [CFG_W-1:0] RST_TOTAL = 16'd1000;
	localparam logic [CFG_W-1:0] RST_BLEND = 16'd250;
	localparam logic [SPEED_W-1:0] RST_SPEED = 16'd8192;
	localparam logic [TOL_W-1:0] RST_TOL   = 15'd205;

	typedef enum logic [CIDX_W-1:0] {
		REG_MODE  = 3'd0,
		REG_TOTAL = 3'd1,
		REG_BLEND = 3'd2,
		REG_SPEED = 3'd3,
		REG_TOL   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_RISE = 2'd0,
		PH_HOLD = 2'd1,
		PH_FALL = 2'd2,
		PH_ZERO = 2'd3
	} phase_t;

endpackage

[hdl/jvp_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; carries an opaque sideband word alongside each request.
module jvp_div #(
	parameter int NUM_W  = 16,
	parameter int DEN_W  = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  in_rem,   // must be below in_den
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              valid_s [0:NUM_W];
	logic [DEN_W-1:0]  rem_s   [0:NUM_W];
	logic [NUM_W-1:0]  num_s   [0:NUM_W]; // dividend bits out, quotient bits in
	logic [DEN_W-1:0]  den_s   [0:NUM_W];
	logic [SIDE_W-1:0] side_s  [0:NUM_W];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = in_rem;
	assign num_s[0]   = in_num;
	assign den_s[0]   = in_den;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[k], num_s[k][NUM_W-1]};
			diff  = trial - {1'b0, den_s[k]};
			ge    = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_s[k+1]  <= {num_s[k][NUM_W-2:0], ge};
			den_s[k+1]  <= den_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[NUM_W];
	assign out_quo   = num_s[NUM_W];
	assign out_side  = side_s[NUM_W];

endmodule

[hdl/joint_velocity_profile.sv]
// Top level of the joint velocity profile block: trapezoidal or relative
// velocity command per control tick. Uses jvp_pkg and jvp_div.
//
//  channel   | signals                                        | flow
//  ----------+------------------------------------------------+------------------
//  request   | start, busy, elapsed_ms, demand_pos, start_pos,| taken on start&!busy
//            | current_pos, max_travel                        |
//  result    | done, velocity, at_target, status              | one-cycle strobe
//  config    | cfg_we, cfg_index, cfg_data                    | write on cfg_we
//
// A request is taken every cycle; busy never rises. The path runs through the
// two bit-serial divider pipelines: the peak divide (one stage per dividend bit)
// and the 15-bit saturating ramp/relative divide. Reset clears the valid chain
// and loads the register defaults. The receiver cannot stall, so the pipeline
// advances every cycle and results leave in request order.
module joint_velocity_profile import jvp_pkg::*; #(
	parameter int POS_WIDTH  = 16,
	parameter int TIME_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [TIME_WIDTH-1:0]       elapsed_ms,
	input  logic signed [POS_WIDTH-1:0] demand_pos,
	input  logic signed [POS_WIDTH-1:0] start_pos,
	input  logic signed [POS_WIDTH-1:0] current_pos,
	input  logic [POS_WIDTH-1:0]        max_travel,
	output logic                        done,
	output logic signed [OUT_W-1:0]     velocity,
	output logic                        at_target,
	output logic                        status,
	input  logic                        cfg_we,
	input  logic [CIDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);

	localparam int P   = POS_WIDTH;
	localparam int TW  = TIME_WIDTH;
	localparam int DW  = P + 1;                       // absolute position difference
	localparam int CW  = (DW > TOL_W) ? DW : TOL_W;   // deadband compare width
	localparam int NW1 = DW + PEAK_K_W;               // peak dividend / quotient
	localparam int RW  = DW + SPEED_W;                // relative numerator
	localparam int MW  = NW1 + TW;                    // peak * ramp time
	localparam int NW2 = (MW > RW) ? MW : RW;         // second dividend
	localparam int DV2 = (P > TW) ? P : TW;           // second divisor
	localparam int HW  = NW2 - QUO_W;                 // dividend bits above quotient

	// ---------------- configuration registers
	logic                mode_q;
	logic [TW-1:0]       total_q;
	logic [TW-1:0]       blend_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [TOL_W-1:0]    tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= RST_MODE;
			total_q <= TW'(RST_TOTAL);
			blend_q <= TW'(RST_BLEND);
			speed_q <= RST_SPEED;
			tol_q   <= RST_TOL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[0];
				REG_TOTAL: total_q <= TW'(cfg_data);
				REG_BLEND: blend_q <= TW'(cfg_data);
				REG_SPEED: speed_q <= cfg_data[SPEED_W-1:0];
				REG_TOL:   tol_q   <= cfg_data[TOL_W-1:0];
				default:   ;
			endcase
		end
	end

	assign busy = 1'b0;

	// ---------------- s1: capture request
	logic                valid_s1;
	logic [TW-1:0]       t_s1;
	logic signed [P-1:0] dem_s1, st_s1, cur_s1;
	logic [P-1:0]        maxd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		t_s1    <= elapsed_ms;
		dem_s1  <= demand_pos;
		st_s1   <= start_pos;
		cur_s1  <= current_pos;
		maxd_s1 <= max_travel;
	end

	// ---------------- s2: distances, profile phase, divide checks
	logic signed [DW-1:0] dc_diff, ds_diff;
	logic signed [TW:0]   span;           // T - Tb
	logic [TW-1:0]        span_abs;
	logic [DW-1:0]        dist_c, dist_st;
	phase_t               phase_c;
	logic [TW-1:0]        x_c;

	always_comb begin
		dc_diff  = DW'(dem_s1) - DW'(cur_s1);
		ds_diff  = DW'(dem_s1) - DW'(st_s1);
		dist_c   = dc_diff[DW-1] ? DW'(-dc_diff) : DW'(dc_diff);
		dist_st  = ds_diff[DW-1] ? DW'(-ds_diff) : DW'(ds_diff);
		span     = $signed({1'b0, total_q}) - $signed({1'b0, blend_q});
		span_abs = span[TW] ? TW'(-span) : span[TW-1:0];
		x_c      = t_s1;
		if (t_s1 < blend_q) begin
			phase_c = PH_RISE;
		end else if ($signed({1'b0, t_s1}) < span) begin
			phase_c = PH_HOLD;
		end else if (t_s1 < total_q) begin
			phase_c = PH_FALL;
			x_c     = total_q - t_s1;
		end else begin
			phase_c = PH_ZERO;
		end
	end

	logic          valid_s2;
	logic [DW-1:0] dist_s2, dist_st_s2;
	logic [TW-1:0] span_abs_s2, x_s2;
	phase_t        phase_s2;
	logic          neg_s2, stat_s2, at_s2, en_s2, mode_s2;
	logic [P-1:0]  maxd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		dist_s2     <= dist_c;
		dist_st_s2  <= dist_st;
		span_abs_s2 <= span_abs;
		x_s2        <= x_c;
		phase_s2    <= phase_c;
		mode_s2     <= mode_q;
		maxd_s2     <= maxd_s1;
		// blend longer than total flips the peak sign
		neg_s2      <= (dem_s1 < cur_s1) ^ (mode_q && span[TW]);
		stat_s2     <= mode_q ? (span == '0) : (maxd_s1 == '0);
		at_s2       <= CW'(dist_c) < CW'(tol_q);
		en_s2       <= CW'(dist_c) > CW'(tol_q);
	end

	// ---------------- s3: constant scale and relative numerator
	typedef struct packed {
		logic          status;
		logic          neg;
		logic          at_target;
		logic          vel_en;
		logic          mode;
		phase_t        phase;
		logic [TW-1:0] x;
		logic [RW-1:0] rel;
		logic [P-1:0]  maxd;
	} side1_t;

	logic           valid_s3;
	logic [NW1-1:0] num1_s3;
	logic [TW-1:0]  den1_s3;
	side1_t         side1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else         valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		num1_s3            <= NW1'(dist_st_s2) * NW1'(PEAK_K);
		// zero span is flagged; a unit divisor keeps the divider tame
		den1_s3            <= (span_abs_s2 == '0) ? TW'(1) : span_abs_s2;
		side1_s3.status    <= stat_s2;
		side1_s3.neg       <= neg_s2;
		side1_s3.at_target <= at_s2;
		side1_s3.vel_en    <= en_s2;
		side1_s3.mode      <= mode_s2;
		side1_s3.phase     <= phase_s2;
		side1_s3.x         <= x_s2;
		side1_s3.rel       <= RW'(dist_s2) * RW'(speed_q);
		side1_s3.maxd      <= maxd_s2;
	end

	// ---------------- peak = 2000*D / |T-Tb|
	logic           valid_p;
	logic [NW1-1:0] peak_p;
	side1_t         side1_p;

	jvp_div #(
		.NUM_W  (NW1),
		.DEN_W  (TW),
		.SIDE_W ($bits(side1_t))
	) u_peak_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_rem    ('0),
		.in_num    (num1_s3),
		.in_den    (den1_s3),
		.in_side   (side1_s3),
		.out_valid (valid_p),
		.out_quo   (peak_p),
		.out_side  (side1_p)
	);

	// ---------------- s4: numerator and divisor of the magnitude divide
	logic           valid_s4;
	logic [NW2-1:0] num2_s4;
	logic [DV2-1:0] den2_s4;
	side1_t         side1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else         valid_s4 <= valid_p;
	end

	always_ff @(posedge clk) begin
		side1_s4 <= side1_p;
		if (!side1_p.mode) begin
			num2_s4 <= NW2'(side1_p.rel);
			den2_s4 <= (side1_p.maxd == '0) ? DV2'(1) : DV2'(side1_p.maxd);
		end else begin
			case (side1_p.phase) inside
				PH_RISE, PH_FALL: begin
					num2_s4 <= NW2'(MW'(peak_p) * MW'(side1_p.x));
					den2_s4 <= DV2'(blend_q);
				end
				PH_HOLD: begin
					num2_s4 <= NW2'(peak_p);
					den2_s4 <= DV2'(1);
				end
				default: begin
					num2_s4 <= '0;
					den2_s4 <= DV2'(1);
				end
			endcase
		end
	end

	// ---------------- s5: saturation check, divider seed
	typedef struct packed {
		logic status;
		logic neg;
		logic at_target;
		logic vel_en;
		logic ovf;
	} side2_t;

	localparam int CMPW = (HW > DV2) ? HW : DV2;

	logic [HW-1:0]    num_hi;
	logic             valid_s5;
	logic [DV2-1:0]   rem_s5;
	logic [QUO_W-1:0] num_lo_s5;
	logic [DV2-1:0]   den2_s5;
	side2_t           side2_s5;

	assign num_hi = num2_s4[NW2-1:QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s5 <= 1'b0;
		else         valid_s5 <= valid_s4;
	end

	always_ff @(posedge clk) begin
		side2_s5.status    <= side1_s4.status;
		side2_s5.neg       <= side1_s4.neg;
		side2_s5.at_target <= side1_s4.at_target;
		side2_s5.vel_en    <= side1_s4.vel_en;
		// quotient would reach 2^15: saturated either way
		side2_s5.ovf       <= CMPW'(num_hi) >= CMPW'(den2_s4);
		rem_s5             <= (CMPW'(num_hi) >= CMPW'(den2_s4)) ? '0 : DV2'(num_hi);
		num_lo_s5          <= num2_s4[QUO_W-1:0];
		den2_s5            <= den2_s4;
	end

	logic             valid_q;
	logic [QUO_W-1:0] quo_q;
	side2_t           side2_q;

	jvp_div #(
		.NUM_W  (QUO_W),
		.DEN_W  (DV2),
		.SIDE_W ($bits(side2_t))
	) u_mag_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s5),
		.in_rem    (rem_s5),
		.in_num    (num_lo_s5),
		.in_den    (den2_s5),
		.in_side   (side2_s5),
		.out_valid (valid_q),
		.out_quo   (quo_q),
		.out_side  (side2_q)
	);

	// ---------------- output: sign, saturate, deadband
	logic [OUT_W-1:0] mag;
	logic [OUT_W-1:0] vel_c;

	always_comb begin
		mag = side2_q.ovf ? VEL_NEG_MAG : {1'b0, quo_q};
		if (side2_q.status || !side2_q.vel_en) begin
			vel_c = '0;
		end else if (side2_q.neg) begin
			vel_c = -mag;
		end else begin
			vel_c = side2_q.ovf ? VEL_POS_MAX : mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= valid_q;
	end

	always_ff @(posedge clk) begin
		velocity  <= $signed(vel_c);
		at_target <= side2_q.at_target;
		status    <= side2_q.status;
	end

endmodule

[dv/tb.sv]
// Testbench for joint_velocity_profile: trapezoidal and relative velocity modes.
// Depends on jvp_pkg and the block RTL; predicts each result and checks in order.
`timescale 1ns / 100ps

module tb;
	import jvp_pkg::*;

	localparam int PW = 16;
	localparam int TW = 16;
	localparam int LATENCY = PW + PEAK_K_W + 22;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic signed [OUT_W-1:0] velocity;
		logic                    at_target;
		logic                    status;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [TW-1:0] elapsed_ms = '0;
	logic signed [PW-1:0] demand_pos = '0;
	logic signed [PW-1:0] start_pos = '0;
	logic signed [PW-1:0] current_pos = '0;
	logic [PW-1:0] max_travel = '0;
	logic done;
	logic signed [OUT_W-1:0] velocity;
	logic at_target;
	logic status;
	logic cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// shadow copy of the register file
	logic             sh_mode;
	logic [TW-1:0]    sh_total;
	logic [TW-1:0]    sh_blend;
	logic [SPEED_W-1:0] sh_speed;
	logic [TOL_W-1:0] sh_tol;

	tick_result_t expected_q[$];
	int unsigned mismatches = 0;
	int unsigned n_requests = 0;
	int unsigned n_results = 0;
	int unsigned n_cfg = 0;
	int unsigned idle_cycles = 0;

	always #1 clk = ~clk;

	joint_velocity_profile #(.POS_WIDTH(PW), .TIME_WIDTH(TW)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.elapsed_ms(elapsed_ms), .demand_pos(demand_pos), .start_pos(start_pos),
		.current_pos(current_pos), .max_travel(max_travel), .done(done),
		.velocity(velocity), .at_target(at_target), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// floor(p*x/d) without losing bits; d nonzero
	function automatic longint unsigned ramp_mag(longint unsigned p, longint unsigned x,
			longint unsigned d);
		return (p / d) * x + ((p % d) * x) / d;
	endfunction

	function automatic tick_result_t predict_velocity(logic [TW-1:0] t,
			logic signed [PW-1:0] dem, logic signed [PW-1:0] st,
			logic signed [PW-1:0] cur, logic [PW-1:0] maxd);
		tick_result_t r;
		longint signed err_s, span, tt, tot, bl;
		longint unsigned err_mag, mag, peak, adiv;
		logic neg;
		logic stat;
		err_s = longint'(dem) - longint'(cur);
		err_mag = (err_s < 0) ? -err_s : err_s;
		neg = dem < cur;
		mag = 0;
		stat = 1'b0;
		if (sh_mode) begin
			tt = t;
			tot = sh_total;
			bl = sh_blend;
			span = tot - bl;
			if (span == 0) begin
				stat = 1'b1;
			end else begin
				adiv = (span < 0) ? -span : span;
				peak = (2000 * ((longint'(dem) >= longint'(st)) ?
					longint'(dem) - longint'(st) : longint'(st) - longint'(dem))) / adiv;
				if (span < 0) neg = ~neg;
				if (tt < bl) mag = ramp_mag(peak, tt, bl);
				else if (tt < span) mag = peak;
				else if (tt < tot) mag = ramp_mag(peak, tot - tt, bl);
				else mag = 0;
			end
		end else begin
			if (maxd == 0) stat = 1'b1;
			else mag = (err_mag * sh_speed) / maxd;
		end
		r.velocity = '0;
		if (!stat && err_mag != 0 && err_mag > sh_tol) begin
			if (neg) r.velocity = (mag >= 32768) ? VEL_NEG_MAG : -mag[OUT_W-1:0];
			else r.velocity = (mag > 32767) ? VEL_POS_MAX : mag[OUT_W-1:0];
		end
		r.at_target = err_mag < sh_tol;
		r.status = stat;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
	endtask

	// result checker: done is a one-cycle strobe, sampled at the edge ending it
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				tick_result_t e;
				e = expected_q.pop_front();
				if (velocity !== e.velocity) report_mismatch("velocity", velocity, e.velocity);
				if (at_target !== e.at_target)
					report_mismatch("at_target", at_target, e.at_target);
				if (status !== e.status) report_mismatch("status", status, e.status);
			end
			n_results++;
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired");
			$display("Some tests failed");
			$finish;
		end
	end

	// send one request after a random gap; prediction taken at acceptance
	task automatic send_request(logic [TW-1:0] t, logic signed [PW-1:0] dem,
			logic signed [PW-1:0] st, logic signed [PW-1:0] cur, logic [PW-1:0] maxd,
			bit gaps = 1);
		int gap;
		gap = gaps ? $urandom_range(0, 7) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0; // runs of back-to-back requests
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		elapsed_ms <= t;
		demand_pos <= dem;
		start_pos <= st;
		current_pos <= cur;
		max_travel <= maxd;
		do @(posedge clk); while (busy);
		expected_q = {expected_q, predict_velocity(t, dem, st, cur, maxd)};
		n_requests++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MODE:  sh_mode = val[0];
			REG_TOTAL: sh_total = val[TW-1:0];
			REG_BLEND: sh_blend = val[TW-1:0];
			REG_SPEED: sh_speed = val;
			REG_TOL:   sh_tol = val[TOL_W-1:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic set_profile(logic m, logic [15:0] tot, logic [15:0] bl,
			logic [15:0] spd, logic [14:0] tol);
		drain();
		write_reg(REG_MODE, CFG_W'(m));
		write_reg(REG_TOTAL, tot);
		write_reg(REG_BLEND, bl);
		write_reg(REG_SPEED, spd);
		write_reg(REG_TOL, CFG_W'(tol));
	endtask

	task automatic send_random(int n, bit well_formed);
		logic signed [PW-1:0] dem, cur;
		logic [TW-1:0] t;
		for (int i = 0; i < n; i++) begin
			dem = PW'($urandom);
			cur = well_formed ? PW'(dem + $signed(PW'($urandom_range(0, 1200))) - 600)
				: PW'($urandom);
			// time mostly up to twice the move length, sometimes any 16-bit value
			t = ($urandom_range(0, 3) == 0) ? TW'($urandom)
				: TW'($urandom_range(0, 2 * sh_total + 2));
			send_request(t, dem, PW'($urandom), cur,
				($urandom_range(0, 9) == 0) ? '0 : PW'($urandom));
		end
	endtask

	// defaults after reset, field extremes, deadband edges
	task automatic test_directed_defaults();
		send_request(0, 16'sh7fff, 16'sh8000, 0, 0);
		send_request(125, 16'sh7fff, 16'sh8000, 16'sh8000, 16'hffff);
		send_request(500, 16'sh8000, 16'sh7fff, 16'sh7fff, 1);
		send_request(900, 1000, 0, 0, 100);
		send_request(1000, 1000, 0, 0, 100);
		send_request(16'hffff, 1000, 0, 0, 100);
		send_request(400, 300, 0, 300, 5);          // zero distance
		send_request(400, 300, 0, 95, 5);           // distance equals tolerance
		send_request(400, 300, 0, 96, 5);           // just inside tolerance
		send_request(400, 300, 0, 94, 5);
	endtask

	task automatic test_special_profiles();
		set_profile(1, 500, 500, 1, 0);             // zero trapezoid divisor
		send_request(100, 4000, 0, 0, 1);
		send_request(100, 0, 0, 0, 1);
		set_profile(1, 100, 400, 1, 0);             // blend longer than total
		send_request(50, 4000, 0, 0, 1);
		send_request(200, 4000, 0, 0, 1);
		send_request(450, 4000, 0, 0, 1);
		set_profile(1, 300, 0, 1, 0);               // zero blend time
		send_request(0, 4000, 0, 0, 1);
		send_request(299, 4000, 0, 0, 1);
		send_request(300, 4000, 0, 0, 1);
		set_profile(0, 1, 1, 16'hffff, 15'h7fff);   // relative, max tolerance
		send_request(0, 16'sh7fff, 0, 16'sh8000, 1);
		send_request(0, 100, 0, 0, 0);              // zero largest distance
		set_profile(0, 16'hffff, 16'hffff, 16'hffff, 0);
		send_request(0, 16'sh7fff, 0, 16'sh8000, 1);
		send_request(0, 16'sh8000, 0, 16'sh7fff, 1);
		send_request(0, 20, 0, 0, 16'hffff);
	endtask

	task automatic test_random_settings();
		logic [15:0] tot;
		for (int p = 0; p < 14; p++) begin
			tot = (p % 4 == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
			set_profile(p[0], tot,
				(p == 5) ? tot : ((p % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, tot))),
				16'($urandom_range(1, 16'hffff)),
				(p % 5 == 0) ? 15'($urandom) : 15'($urandom_range(0, 400)));
			send_random(80, 1);
			send_random(25, 0);
		end
	endtask

	initial begin
		sh_mode = RST_MODE;
		sh_total = RST_TOTAL;
		sh_blend = RST_BLEND;
		sh_speed = RST_SPEED;
		sh_tol = RST_TOL;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_special_profiles();
		test_random_settings();
		drain();
		$display("Sent %0d requests, checked %0d results over %0d register writes",
			n_requests, n_results, n_cfg);
		if (mismatches == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
